>>> rtl/round_robin_thread_scheduler_defines.svh
// ---------------------------------------------------------------------------
// Round-robin thread scheduler: assertion macros
// Clocked assertion helpers shared by the scheduler RTL.
// ---------------------------------------------------------------------------
`ifndef ROUND_ROBIN_THREAD_SCHEDULER_DEFINES_SVH
`define ROUND_ROBIN_THREAD_SCHEDULER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// property checked at every edge outside reset
`define RRTS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property checked at every edge, reset included
`define RRTS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define RRTS_ASSERT(label, clk, rst, prop, msg)
`define RRTS_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

>>> rtl/rrts_pkg.sv
// ---------------------------------------------------------------------------
// rrts_pkg
// Event codes, status codes and stage types for the thread scheduler.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rrts_pkg;

   localparam int OP_W     = 3;
   localparam int SLOT_W   = 4;
   localparam int STATUS_W = 2;

   typedef enum logic [OP_W-1:0] {
      OP_CREATE   = 3'd0,
      OP_WAKEUP   = 3'd1,
      OP_SLEEP    = 3'd2,
      OP_TICK     = 3'd3,
      OP_YIELD    = 3'd4,
      OP_YIELD_IF = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE    = 2'd0,
      ST_IGNORED = 2'd1,
      ST_REFUSED = 2'd2
   } status_type;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [SLOT_W-1:0] thread_slot;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0] running_slot;
      logic              running_is_idle;
      logic              switched;
      status_type        status;
   } rsp_type;

endpackage

`default_nettype wire

>>> rtl/rrts_in_reg.sv
// ---------------------------------------------------------------------------
// rrts_in_reg
// Input register: captures one request item and holds it until the core
// takes it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rrts_in_reg
   import rrts_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire req_type in_req,
   output logic         out_valid,
   input  wire logic    out_take,
   output req_type      out_req
);

   logic    valid_ff;
   logic    valid_in;
   req_type req_ff;

   assign in_ready  = !valid_ff || out_take;
   assign valid_in  = (in_valid && in_ready) || (valid_ff && !out_take);
   assign out_valid = valid_ff;
   assign out_req   = req_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         req_ff <= in_req;
      end
   end

endmodule

`default_nettype wire

>>> rtl/rrts_core.sv
// ---------------------------------------------------------------------------
// rrts_core
// Run queue state and single-pass event logic: ready ring links, slot
// flags, yield flags and the running thread.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "round_robin_thread_scheduler_defines.svh"

module rrts_core
   import rrts_pkg::*;
#(
   parameter int THREAD_SLOTS = 16
)
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    fire,
   input  wire req_type req,
   output rsp_type      rsp
);

   localparam int SW = $clog2(THREAD_SLOTS);
   localparam int CW = $clog2(THREAD_SLOTS + 1);
   localparam int XW = (SW > SLOT_W) ? SW : SLOT_W;

   logic [SW-1:0]           succ_ff [THREAD_SLOTS];
   logic [SW-1:0]           succ_in [THREAD_SLOTS];
   logic [SW-1:0]           pred_ff [THREAD_SLOTS];
   logic [SW-1:0]           pred_in [THREAD_SLOTS];
   logic [THREAD_SLOTS-1:0] used_ff, used_in;
   logic [THREAD_SLOTS-1:0] sleep_ff, sleep_in;
   logic [THREAD_SLOTS-1:0] yield_ff, yield_in;
   logic                    idle_yield_ff, idle_yield_in;
   logic [SW-1:0]           run_ff, run_in;
   logic                    idle_ff, idle_in;
   logic [SW-1:0]           head_ff, head_in;
   logic [CW-1:0]           count_ff, count_in;

   logic [XW-1:0] slot_ext;
   logic [SW-1:0] slot_idx;
   logic          slot_ok;
   logic [SW-1:0] tail;
   logic [SW-1:0] run_pred;
   logic [SW-1:0] run_succ;
   logic          cur_flag;
   logic [XW-1:0] run_ext;
   status_type    status;

   assign slot_ext = XW'(req.thread_slot);
   assign slot_idx = slot_ext[SW-1:0];
   assign slot_ok  = (32'(slot_ext) < 32'(THREAD_SLOTS));
   assign tail     = pred_ff[head_ff];
   assign run_pred = pred_ff[run_ff];
   assign run_succ = succ_ff[run_ff];
   assign cur_flag = idle_ff ? idle_yield_ff : yield_ff[run_ff];

   always_comb begin
      succ_in       = succ_ff;
      pred_in       = pred_ff;
      used_in       = used_ff;
      sleep_in      = sleep_ff;
      yield_in      = yield_ff;
      idle_yield_in = idle_yield_ff;
      run_in        = run_ff;
      idle_in       = idle_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      status        = ST_DONE;

      case (req.operation)
         OP_CREATE, OP_WAKEUP: begin
            if (!slot_ok || (req.operation == OP_CREATE && used_ff[slot_idx]) ||
                (req.operation == OP_WAKEUP && !used_ff[slot_idx])) begin
               status = ST_REFUSED;
            end else if (req.operation == OP_WAKEUP &&
                         ((!idle_ff && slot_idx == run_ff) || !sleep_ff[slot_idx])) begin
               status = ST_IGNORED;
            end else begin
               used_in[slot_idx]  = 1'b1;
               sleep_in[slot_idx] = 1'b0;
               if (req.operation == OP_CREATE) begin
                  yield_in[slot_idx] = 1'b0;
               end
               // insert at head of the ready ring
               if (count_ff == '0) begin
                  succ_in[slot_idx] = slot_idx;
                  pred_in[slot_idx] = slot_idx;
               end else begin
                  succ_in[slot_idx] = head_ff;
                  pred_in[slot_idx] = tail;
                  succ_in[tail]     = slot_idx;
                  pred_in[head_ff]  = slot_idx;
               end
               head_in  = slot_idx;
               count_in = count_ff + CW'(1);
               if (idle_ff) begin
                  idle_yield_in = 1'b1;
               end else begin
                  yield_in[run_ff] = 1'b1;
               end
            end
         end
         OP_SLEEP: begin
            if (idle_ff) begin
               status = ST_REFUSED;
            end else begin
               sleep_in[run_ff] = 1'b1;
               if (count_ff <= CW'(1)) begin
                  count_in = '0;
                  idle_in  = 1'b1;
                  run_in   = '0;
               end else begin
                  succ_in[run_pred] = run_succ;
                  pred_in[run_succ] = run_pred;
                  if (head_ff == run_ff) begin
                     head_in = run_succ;
                  end
                  count_in = count_ff - CW'(1);
                  run_in   = run_succ;
               end
            end
         end
         OP_TICK: begin
            if (idle_ff) begin
               idle_yield_in = 1'b1;
            end else begin
               yield_in[run_ff] = 1'b1;
            end
         end
         OP_YIELD, OP_YIELD_IF: begin
            if (req.operation == OP_YIELD_IF && !cur_flag) begin
               status = ST_IGNORED;
            end else begin
               if (idle_ff) begin
                  idle_yield_in = 1'b0;
               end else begin
                  yield_in[run_ff] = 1'b0;
               end
               if (count_ff == '0) begin
                  idle_in = 1'b1;
                  run_in  = '0;
               end else if (idle_ff) begin
                  idle_in = 1'b0;
                  run_in  = head_ff;
               end else begin
                  run_in = run_succ;
               end
            end
         end
         default: begin
            status = ST_IGNORED;
         end
      endcase
   end

   assign run_ext             = XW'(run_in);
   assign rsp.running_slot    = idle_in ? '0 : run_ext[SLOT_W-1:0];
   assign rsp.running_is_idle = idle_in;
   assign rsp.switched        = (idle_ff != idle_in) || (!idle_in && run_ff != run_in);
   assign rsp.status          = status;

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff       <= '0;
         sleep_ff      <= '0;
         yield_ff      <= '0;
         idle_yield_ff <= 1'b0;
         run_ff        <= '0;
         idle_ff       <= 1'b1;
         head_ff       <= '0;
         count_ff      <= '0;
      end else if (fire) begin
         used_ff       <= used_in;
         sleep_ff      <= sleep_in;
         yield_ff      <= yield_in;
         idle_yield_ff <= idle_yield_in;
         run_ff        <= run_in;
         idle_ff       <= idle_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
      end
   end

   // link registers have no reset
   always_ff @(posedge clock) begin
      if (fire) begin
         succ_ff <= succ_in;
         pred_ff <= pred_in;
      end
   end

   `RRTS_ASSERT(a_idle_slot_zero, clock, reset, idle_ff |-> (run_ff == '0),
                "idle thread running with nonzero slot")
   `RRTS_ASSERT(a_run_on_ring, clock, reset, !idle_ff |-> (count_ff != '0),
                "thread running while ready ring is empty")
   `RRTS_ASSERT(a_run_awake, clock, reset,
                !idle_ff |-> (used_ff[run_ff] && !sleep_ff[run_ff]),
                "running slot is unused or sleeping")
   `RRTS_ASSERT(a_count_match, clock, reset,
                32'(count_ff) == $countones(used_ff & ~sleep_ff),
                "ready count disagrees with awake slots")

endmodule

`default_nettype wire

>>> rtl/round_robin_thread_scheduler.sv
// Path: a request item passes through the input register and the result register to
// the rsp_ ports, and waits in the input register while a stalled result holds it.
// Throughput: one item per cycle unless rsp_ready stalls; the core resolves each event in a single
// pass over the link registers, and the result register frees the input whenever it advances.
// Reset: synchronous; idle runs, ready ring empty, all slot and yield flags clear.
// Ring link registers are not reset; only links of slots on the ring are ever read.
// ---------------------------------------------------------------------------
// round_robin_thread_scheduler
// Hardware run queue: input register, event core and result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module round_robin_thread_scheduler
   import rrts_pkg::*;
#(
   parameter int THREAD_SLOTS = 16
)
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [OP_W-1:0]     req_operation,
   input  wire logic [SLOT_W-1:0]   req_thread_slot,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [SLOT_W-1:0]        rsp_running_slot,
   output logic                     rsp_running_is_idle,
   output logic                     rsp_switched,
   output logic [STATUS_W-1:0]      rsp_status
);

   req_type in_req;
   req_type stage_req;
   logic    stage_valid;
   logic    take;
   rsp_type core_rsp;
   rsp_type rsp_ff;
   logic    rsp_valid_ff, rsp_valid_in;

   assign in_req.operation   = req_operation;
   assign in_req.thread_slot = req_thread_slot;

   assign take         = stage_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid_in = take || (rsp_valid_ff && !rsp_ready);

   rrts_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_req    (in_req),
      .out_valid (stage_valid),
      .out_take  (take),
      .out_req   (stage_req)
   );

   rrts_core #(
      .THREAD_SLOTS (THREAD_SLOTS)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .fire  (take),
      .req   (stage_req),
      .rsp   (core_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= core_rsp;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_running_slot    = rsp_ff.running_slot;
   assign rsp_running_is_idle = rsp_ff.running_is_idle;
   assign rsp_switched        = rsp_ff.switched;
   assign rsp_status          = rsp_ff.status;

endmodule

`default_nettype wire

>>> tb/sv/tb_round_robin_thread_scheduler.sv
// ---------------------------------------------------------------------------
// tb_round_robin_thread_scheduler
// Drives scheduler events through the valid/ready request port and checks
// every response against an in-bench run queue that tracks the ready ring,
// slot and yield flags. A short directed sequence hits the refusals and
// corner cases, then weighted random events run with bursty requests and
// patterned response back-pressure.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_round_robin_thread_scheduler;
   import rrts_pkg::*;

   localparam int SLOTS        = 16;
   localparam int RANDOM_ITEMS = 1780;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 8;

   // codes outside the defined event set
   localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

   class run_queue_checker;
      logic [SLOT_W-1:0] running;
      logic [SLOT_W-1:0] head;
      bit                idle;
      int unsigned       count;
      logic [SLOT_W-1:0] next_link[SLOTS];
      logic [SLOT_W-1:0] prev_link[SLOTS];
      bit                in_use[SLOTS];
      bit                sleeping[SLOTS];
      bit                flagged[SLOTS+1];
      rsp_type           outcome_q[$];
      int unsigned       error_count;

      function new();
         running = '0;
         head    = '0;
         idle    = 1'b1;
         count   = 0;
         error_count = 0;
         for (int i = 0; i < SLOTS; i++) begin
            next_link[i] = '0;
            prev_link[i] = '0;
            in_use[i]    = 1'b0;
            sleeping[i]  = 1'b0;
         end
         for (int i = 0; i <= SLOTS; i++) flagged[i] = 1'b0;
      endfunction

      function int unsigned cur_index();
         return idle ? SLOTS : int'(running);
      endfunction

      function void push_front(logic [SLOT_W-1:0] s);
         logic [SLOT_W-1:0] tail;
         if (count == 0) begin
            next_link[s] = s;
            prev_link[s] = s;
         end else begin
            tail = prev_link[head];
            next_link[s] = head;
            prev_link[s] = tail;
            next_link[tail] = s;
            prev_link[head] = s;
         end
         head = s;
         count++;
         flagged[cur_index()] = 1'b1;
      endfunction

      function void choose(logic [SLOT_W-1:0] from, bit from_idle);
         if (count == 0) begin
            idle    = 1'b1;
            running = '0;
         end else if (from_idle) begin
            idle    = 1'b0;
            running = head;
         end else begin
            idle    = 1'b0;
            running = next_link[from];
         end
      endfunction

      function void note_event(logic [OP_W-1:0] op, logic [SLOT_W-1:0] slot);
         logic [SLOT_W-1:0] was_slot;
         logic [SLOT_W-1:0] p;
         logic [SLOT_W-1:0] n;
         bit                was_idle;
         bit                slot_ok;
         status_type        st;
         rsp_type           outcome;
         was_slot = running;
         was_idle = idle;
         slot_ok  = int'(slot) < SLOTS;
         st       = ST_DONE;
         case (op)
            OP_CREATE: begin
               if (!slot_ok || in_use[slot]) begin
                  st = ST_REFUSED;
               end else begin
                  in_use[slot]   = 1'b1;
                  sleeping[slot] = 1'b0;
                  flagged[slot]  = 1'b0;
                  push_front(slot);
               end
            end
            OP_WAKEUP: begin
               if (!slot_ok || !in_use[slot]) begin
                  st = ST_REFUSED;
               end else if ((!idle && slot == running) || !sleeping[slot]) begin
                  st = ST_IGNORED;
               end else begin
                  sleeping[slot] = 1'b0;
                  push_front(slot);
               end
            end
            OP_SLEEP: begin
               if (idle) begin
                  st = ST_REFUSED;
               end else begin
                  sleeping[was_slot] = 1'b1;
                  if (count <= 1) begin
                     count = 0;
                  end else begin
                     p = prev_link[was_slot];
                     n = next_link[was_slot];
                     next_link[p] = n;
                     prev_link[n] = p;
                     if (head == was_slot) head = n;
                     count--;
                  end
                  choose(was_slot, 1'b0);
               end
            end
            OP_TICK: flagged[cur_index()] = 1'b1;
            OP_YIELD, OP_YIELD_IF: begin
               if (op == OP_YIELD_IF && !flagged[cur_index()]) begin
                  st = ST_IGNORED;
               end else begin
                  flagged[cur_index()] = 1'b0;
                  choose(was_slot, was_idle);
               end
            end
            default: st = ST_IGNORED;
         endcase
         outcome.running_slot    = idle ? '0 : running;
         outcome.running_is_idle = idle;
         outcome.switched        = (was_idle != idle) || (!idle && was_slot != running);
         outcome.status          = st;
         outcome_q.push_back(outcome);
      endfunction

      task report(string what);
         $display("%0t ns: mismatch: %s", $time, what);
         error_count++;
      endtask

      task check_outcome(logic [SLOT_W-1:0] slot, logic is_idle, logic sw,
                         logic [STATUS_W-1:0] st);
         rsp_type want;
         if (outcome_q.size() == 0) begin
            report("response item with nothing outstanding");
            return;
         end
         want = outcome_q.pop_front();
         if (slot !== want.running_slot)
            report($sformatf("running_slot %0d, want %0d", slot, want.running_slot));
         if (is_idle !== want.running_is_idle)
            report($sformatf("running_is_idle %0b, want %0b", is_idle,
                             want.running_is_idle));
         if (sw !== want.switched)
            report($sformatf("switched %0b, want %0b", sw, want.switched));
         if (st !== want.status)
            report($sformatf("status %0d, want %0d", st, want.status));
      endtask
   endclass

   logic                clock           = 1'b0;
   logic                reset           = 1'b1;
   logic                req_valid       = 1'b0;
   logic [OP_W-1:0]     req_operation   = '0;
   logic [SLOT_W-1:0]   req_thread_slot = '0;
   logic                rsp_ready       = 1'b0;
   wire logic                req_ready;
   wire logic                rsp_valid;
   wire logic [SLOT_W-1:0]   rsp_running_slot;
   wire logic                rsp_running_is_idle;
   wire logic                rsp_switched;
   wire logic [STATUS_W-1:0] rsp_status;

   run_queue_checker board = new();

   logic [31:0] ready_mask  = 32'hffff_ffff;
   int          ready_phase = 0;

   round_robin_thread_scheduler #(.THREAD_SLOTS(SLOTS)) dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_operation       (req_operation),
      .req_thread_slot     (req_thread_slot),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_running_slot    (rsp_running_slot),
      .rsp_running_is_idle (rsp_running_is_idle),
      .rsp_switched        (rsp_switched),
      .rsp_status          (rsp_status)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // response side: check, then stall on a ready pattern that is redrawn whenever ready_phase wraps
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_outcome(rsp_running_slot, rsp_running_is_idle, rsp_switched,
                             rsp_status);
      ready_phase = ready_phase + 1;
      if (ready_phase == 64) begin
         ready_phase = 0;
         case ($urandom_range(0, 3))
            0: ready_mask = 32'hffff_ffff;
            1: ready_mask = $urandom;
            2: ready_mask = $urandom & $urandom;
            default: ready_mask = $urandom | $urandom;
         endcase
         ready_mask[0] = 1'b1;
      end
      rsp_ready <= ready_mask[ready_phase[4:0]];
   end

   task automatic send_item(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot);
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_thread_slot <= slot;
      do @(posedge clock); while (!req_ready);
      board.note_event(op, slot);
   endtask

   task automatic pause_sender(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain_sender();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.outcome_q.size() != 0);
   endtask

   task automatic send_random_event();
      int                r;
      int                sleepers[$];
      logic [OP_W-1:0]   op;
      logic [SLOT_W-1:0] slot;
      r    = $urandom_range(0, 99);
      slot = SLOT_W'($urandom_range(0, SLOTS - 1));
      if (r < 6) begin
         op = OP_CREATE;
      end else if (r < 30) begin
         op = OP_WAKEUP;
         for (int i = 0; i < SLOTS; i++)
            if (board.sleeping[i]) sleepers.push_back(i);
         if (sleepers.size() != 0 && $urandom_range(0, 9) < 7)
            slot = SLOT_W'(sleepers[$urandom_range(0, sleepers.size() - 1)]);
      end else if (r < 50) begin
         op = OP_SLEEP;
      end else if (r < 62) begin
         op = OP_TICK;
      end else if (r < 74) begin
         op = OP_YIELD;
      end else if (r < 94) begin
         op = OP_YIELD_IF;
      end else begin
         op = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
      end
      send_item(op, slot);
   endtask

   initial begin
      int sent;
      int burst;
      int gap;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_item(OP_SLEEP, 4'd0);
      send_item(OP_YIELD_IF, 4'd0);
      send_item(OP_WAKEUP, 4'd3);
      send_item(OP_TICK, 4'd0);
      send_item(OP_YIELD_IF, 4'd0);
      send_item(OP_YIELD, 4'd0);
      send_item(OP_CREATE, 4'd0);
      send_item(OP_CREATE, 4'd15);
      send_item(OP_CREATE, 4'd0);
      send_item(OP_YIELD_IF, 4'd0);
      send_item(OP_WAKEUP, 4'd15);
      send_item(OP_WAKEUP, 4'd0);
      send_item(OP_CREATE, 4'd7);
      send_item(OP_YIELD_IF, 4'd0);
      send_item(OP_YIELD, 4'd0);
      send_item(OP_SLEEP, 4'd0);
      send_item(OP_WAKEUP, 4'd7);
      send_item(OP_TICK, 4'd0);
      send_item(OP_SPARE_6, 4'd5);
      send_item(OP_SPARE_7, 4'd10);
      send_item(OP_SLEEP, 4'd0);
      send_item(OP_SLEEP, 4'd0);
      send_item(OP_SLEEP, 4'd0);
      send_item(OP_SLEEP, 4'd0);
      send_item(OP_WAKEUP, 4'd0);
      send_item(OP_YIELD_IF, 4'd0);
      send_item(OP_YIELD, 4'd0);
      drain_sender();

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 24);
         for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
            send_random_event();
            sent++;
         end
         if (sent >= RANDOM_ITEMS) break;
         if (sent % 300 < burst) begin
            drain_sender();
         end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) pause_sender(gap);
         end
      end

      req_valid <= 1'b0;
      while (board.outcome_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.error_count == 0)
         $display("tb_round_robin_thread_scheduler: clean");
      else
         $display("tb_round_robin_thread_scheduler: errors");
      $finish;
   end

   initial begin
      for (int cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
         @(posedge clock);
      $display("%0t ns: run timed out", $time);
      $display("tb_round_robin_thread_scheduler: errors");
      $finish;
   end

endmodule
